// ===== design/assert_macros.svh =====
// Assertion macros used by the RTL sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is active (active-low reset).
`define ASSERT_CLK(lbl, ck, rstn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) prop) else $error(msg);

// Clocked check that a condition never holds outside reset.
`define ASSERT_NEVER_CLK(lbl, ck, rstn, cond, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) !(cond)) else $error(msg);

`endif

// ===== design/alm_pkg.sv =====
// Shared types and codes for the array linked list manager.
package alm_pkg;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } alm_op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } alm_status_t;

  // Write strobes from the sequencer to the link store
  typedef struct packed {
    logic nxt_we;
    logic prv_we;
    logic val_we;
  } alm_wr_t;

endpackage

// ===== design/alm_link_store.sv =====
// Next, prev and value stores: one write per store, one registered read of next and prev.
module alm_link_store #(
  parameter int SLOTS = 256
) (
  input  logic                           clk,
  input  alm_pkg::alm_wr_t               wr,
  input  logic [$clog2(SLOTS)-1:0]       nxt_waddr,
  input  logic [$clog2(SLOTS):0]         nxt_wdata,
  input  logic [$clog2(SLOTS)-1:0]       prv_waddr,
  input  logic [$clog2(SLOTS):0]         prv_wdata,
  input  logic [$clog2(SLOTS)-1:0]       val_waddr,
  input  logic signed [31:0]             val_wdata,
  input  logic                           rd_en,
  input  logic [$clog2(SLOTS)-1:0]       rd_addr,
  output logic [$clog2(SLOTS):0]         nxt_rdata,
  output logic [$clog2(SLOTS):0]         prv_rdata
);

  localparam int IW = $clog2(SLOTS);
  localparam int LW = IW + 1;

  logic [LW-1:0]     nxt_mem [SLOTS];
  logic [LW-1:0]     prv_mem [SLOTS];
  logic signed [31:0] val_mem [SLOTS];

  always_ff @(posedge clk) begin
    if (wr.nxt_we) begin
      nxt_mem[nxt_waddr] <= nxt_wdata;
    end
    if (rd_en) begin
      nxt_rdata <= nxt_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr.prv_we) begin
      prv_mem[prv_waddr] <= prv_wdata;
    end
    if (rd_en) begin
      prv_rdata <= prv_mem[rd_addr];
    end
  end

  // element payload; kept for completeness, no result reads it
  always_ff @(posedge clk) begin
    if (wr.val_we) begin
      val_mem[val_waddr] <= val_wdata;
    end
  end

endmodule

// ===== design/alm_seq.sv =====
// Sequencer: clearing pass, link update steps, pointers and result register.
`include "assert_macros.svh"

module alm_seq #(
  parameter int SLOTS = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_opcode,
  input  logic signed [31:0]          in_value,
  input  logic [7:0]                  in_slot_index,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_status,
  output logic [7:0]                  out_slot_used,
  output logic [7:0]                  out_head_slot,
  output logic                        out_list_empty,
  output alm_pkg::alm_wr_t            wr,
  output logic [$clog2(SLOTS)-1:0]    nxt_waddr,
  output logic [$clog2(SLOTS):0]      nxt_wdata,
  output logic [$clog2(SLOTS)-1:0]    prv_waddr,
  output logic [$clog2(SLOTS):0]      prv_wdata,
  output logic [$clog2(SLOTS)-1:0]    val_waddr,
  output logic signed [31:0]          val_wdata,
  output logic                        rd_en,
  output logic [$clog2(SLOTS)-1:0]    rd_addr,
  input  logic [$clog2(SLOTS):0]      nxt_rdata,
  input  logic [$clog2(SLOTS):0]      prv_rdata
);

  localparam int IW = $clog2(SLOTS);
  localparam int LW = IW + 1;
  localparam logic [LW-1:0] NULL_LINK = LW'(SLOTS);
  localparam logic [IW-1:0] LAST_SLOT = IW'(SLOTS - 1);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_WR1   = 6'b000100,
    S_WR2   = 6'b001000,
    S_WR3   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  function automatic logic is_null(input logic [LW-1:0] link);
    is_null = (link >= NULL_LINK);
  endfunction

  state_t                state_r, state_nxt;
  logic [IW-1:0]         clr_r, clr_nxt;
  logic [LW-1:0]         head_r, head_nxt;
  logic [LW-1:0]         free_r, free_nxt;
  alm_pkg::alm_op_t      op_r, op_nxt;
  logic [IW-1:0]         slot_r, slot_nxt;
  alm_pkg::alm_status_t  status_r, status_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [1:0]            out_status_r;
  logic [7:0]            out_slot_r;
  logic [7:0]            out_head_r;
  logic                  out_empty_r;

  logic [IW-1:0]         slot_mod;
  logic                  in_fire;
  logic                  in_ins;
  logic                  ins;
  logic [LW-1:0]         other;
  logic [LW-1:0]         slot_link;
  logic                  out_free;
  logic                  ld;
  logic [IW+7:0]         slot_ext;
  logic [IW+7:0]         head_ext;

  // slot_index modulo SLOTS
  generate
    if (SLOTS >= 256) begin : g_wide
      assign slot_mod = IW'(in_slot_index);
    end else begin : g_narrow
      localparam logic [8:0] SLOTS9 = 9'(SLOTS);
      logic [8:0] rem;
      always_comb begin
        rem = '0;
        for (int i = 7; i >= 0; i--) begin
          rem = {rem[7:0], in_slot_index[i]};
          if (rem >= SLOTS9) begin
            rem = rem - SLOTS9;
          end
        end
      end
      assign slot_mod = IW'(rem);
    end
  endgenerate

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign in_ins    = (alm_pkg::alm_op_t'(in_opcode) == alm_pkg::OP_INSERT);
  assign ins       = (op_r == alm_pkg::OP_INSERT);
  // insert links to the old head, delete links to the old free head
  assign other     = ins ? head_r : free_r;
  assign slot_link = {1'b0, slot_r};
  assign out_free  = !out_valid_r || out_ready;
  assign ld        = ((state_r == S_WR3) || (state_r == S_DONE)) && out_free;

  assign rd_en   = in_fire;
  assign rd_addr = in_ins ? free_r[IW-1:0] : slot_mod;

  assign val_waddr = free_r[IW-1:0];
  assign val_wdata = in_value;

  // memory write port steering
  always_comb begin
    wr        = '0;
    nxt_waddr = '0;
    nxt_wdata = '0;
    prv_waddr = '0;
    prv_wdata = '0;
    wr.val_we = in_fire && in_ins && !is_null(free_r);
    unique case (state_r)
      S_CLEAR: begin
        wr.nxt_we = 1'b1;
        wr.prv_we = 1'b1;
        nxt_waddr = clr_r;
        nxt_wdata = {1'b0, clr_r} + LW'(1);
        prv_waddr = clr_r;
        prv_wdata = (clr_r == '0) ? NULL_LINK : {1'b0, clr_r} - LW'(1);
      end
      S_WR1: begin
        // insert: prev[next free] = null; delete: prev[after] = before
        wr.prv_we = !is_null(nxt_rdata);
        prv_waddr = nxt_rdata[IW-1:0];
        prv_wdata = ins ? NULL_LINK : prv_rdata;
        // delete: next[before] = after
        wr.nxt_we = !ins && !is_null(prv_rdata);
        nxt_waddr = prv_rdata[IW-1:0];
        nxt_wdata = nxt_rdata;
      end
      S_WR2: begin
        wr.nxt_we = 1'b1;
        nxt_waddr = slot_r;
        nxt_wdata = other;
        wr.prv_we = 1'b1;
        prv_waddr = slot_r;
        prv_wdata = NULL_LINK;
      end
      S_WR3: begin
        wr.prv_we = !is_null(other);
        prv_waddr = other[IW-1:0];
        prv_wdata = slot_link;
      end
      S_IDLE, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // sequencer and pointer updates
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    head_nxt      = head_r;
    free_nxt      = free_r;
    op_nxt        = op_r;
    slot_nxt      = slot_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (ld) begin
      out_valid_nxt = 1'b1;
    end
    unique case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + IW'(1);
        if (clr_r == LAST_SLOT) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          op_nxt   = alm_pkg::alm_op_t'(in_opcode);
          slot_nxt = in_ins ? free_r[IW-1:0] : slot_mod;
          priority if (in_ins && is_null(free_r)) begin
            status_nxt = alm_pkg::ST_FULL;
            state_nxt  = S_DONE;
          end else if (!in_ins && is_null(head_r)) begin
            status_nxt = alm_pkg::ST_EMPTY;
            state_nxt  = S_DONE;
          end else begin
            status_nxt = alm_pkg::ST_OK;
            state_nxt  = S_WR1;
          end
        end
      end
      S_WR1: begin
        if (ins) begin
          free_nxt = nxt_rdata;
        end else if (is_null(prv_rdata)) begin
          head_nxt = nxt_rdata;
        end
        state_nxt = S_WR2;
      end
      S_WR2: begin
        state_nxt = S_WR3;
      end
      S_WR3: begin
        if (ins) begin
          head_nxt = slot_link;
        end else begin
          free_nxt = slot_link;
        end
        state_nxt = ld ? S_IDLE : S_DONE;
      end
      S_DONE: begin
        if (ld) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  assign slot_ext = {8'd0, slot_r};
  assign head_ext = {8'd0, head_nxt[IW-1:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      head_r      <= NULL_LINK;
      free_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      head_r      <= head_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    slot_r   <= slot_nxt;
    status_r <= status_nxt;
    if (ld) begin
      out_status_r <= status_r;
      out_slot_r   <= (status_r == alm_pkg::ST_OK) ? slot_ext[7:0] : 8'd0;
      out_head_r   <= is_null(head_nxt) ? 8'd0 : head_ext[7:0];
      out_empty_r  <= is_null(head_nxt);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_slot_used  = out_slot_r;
  assign out_head_slot  = out_head_r;
  assign out_list_empty = out_empty_r;

  `ASSERT_CLK(a_busy_after_beat, clk, rst_n, in_valid && in_ready |=> !in_ready, "ready after beat")
  `ASSERT_NEVER_CLK(a_bad_link, clk, rst_n, (wr.nxt_we && (nxt_wdata > NULL_LINK)) || (wr.prv_we && (prv_wdata > NULL_LINK)), "link out of range")
  `ASSERT_CLK(a_err_no_change, clk, rst_n, in_fire && ((in_ins && is_null(free_r)) || (!in_ins && is_null(head_r))) |=> $stable(head_r) && $stable(free_r), "state changed on error")
  `ASSERT_NEVER_CLK(a_clear_quiet, clk, rst_n, (state_r == S_CLEAR) && (out_valid_r || wr.val_we), "activity during clear")

endmodule

// ===== design/array_linked_list_manager.sv =====
// Top level of the array doubly linked list manager with free list.
//
//  channel  dir  handshake               beat carries
//  in_      in   in_valid / in_ready     opcode, value, slot_index
//  out_     out  out_valid / out_ready   status, slot_used, head_slot, list_empty
//
// Insert or delete: link read registered at the beat edge, then three write
// steps; the result is loaded in the last one, or held in DONE until the
// output frees. Pool full or list empty: no write steps, result from DONE.
// After reset a clearing pass over all SLOTS entries rebuilds the free chain
// with in_ready low. A waiting result stalls the sequencer only once the
// next item is ready to be reported; the next beat is taken meanwhile.
module array_linked_list_manager #(
  parameter int SLOTS = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_opcode,
  input  logic signed [31:0] in_value,
  input  logic [7:0]         in_slot_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic [7:0]         out_slot_used,
  output logic [7:0]         out_head_slot,
  output logic               out_list_empty
);

  localparam int IW = $clog2(SLOTS);
  localparam int LW = IW + 1;

  // write strobes and ports of the link store
  alm_pkg::alm_wr_t   wr;
  logic [IW-1:0]      nxt_waddr;
  logic [LW-1:0]      nxt_wdata;
  logic [IW-1:0]      prv_waddr;
  logic [LW-1:0]      prv_wdata;
  logic [IW-1:0]      val_waddr;
  logic signed [31:0] val_wdata;
  // registered read of the slot under work
  logic               rd_en;
  logic [IW-1:0]      rd_addr;
  logic [LW-1:0]      nxt_rdata;
  logic [LW-1:0]      prv_rdata;

  // sequencer: clear pass, read, three link write steps, result load
  alm_seq #(
    .SLOTS(SLOTS)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_opcode     (in_opcode),
    .in_value      (in_value),
    .in_slot_index (in_slot_index),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_slot_used (out_slot_used),
    .out_head_slot (out_head_slot),
    .out_list_empty(out_list_empty),
    .wr            (wr),
    .nxt_waddr     (nxt_waddr),
    .nxt_wdata     (nxt_wdata),
    .prv_waddr     (prv_waddr),
    .prv_wdata     (prv_wdata),
    .val_waddr     (val_waddr),
    .val_wdata     (val_wdata),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .nxt_rdata     (nxt_rdata),
    .prv_rdata     (prv_rdata)
  );

  // next / prev / value stores, SLOTS entries each
  alm_link_store #(
    .SLOTS(SLOTS)
  ) u_store (
    .clk      (clk),
    .wr       (wr),
    .nxt_waddr(nxt_waddr),
    .nxt_wdata(nxt_wdata),
    .prv_waddr(prv_waddr),
    .prv_wdata(prv_wdata),
    .val_waddr(val_waddr),
    .val_wdata(val_wdata),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .nxt_rdata(nxt_rdata),
    .prv_rdata(prv_rdata)
  );

endmodule

// ===== tb/sv/alm_checker.sv =====
// Checker for the array linked list manager: mirrors the slot links and compares every result.
`timescale 1ns / 1ps

module alm_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_opcode,
  input  logic [31:0] in_value,
  input  logic [7:0]  in_slot_index,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_status,
  input  logic [7:0]  out_slot_used,
  input  logic [7:0]  out_head_slot,
  input  logic        out_list_empty,
  input  logic        end_of_test,
  output int          errors
);

  localparam int         POOL     = 256;
  localparam logic [8:0] LINK_NIL = 9'(POOL);

  typedef struct packed {
    alm_pkg::alm_status_t status;
    logic [7:0]           slot_used;
    logic [7:0]           head_slot;
    logic                 list_empty;
  } list_result_t;

  logic [8:0]   next_of      [POOL];
  logic [8:0]   prev_of      [POOL];
  logic [31:0]  stored_value [POOL];
  logic [8:0]   head_ptr;
  logic [8:0]   free_ptr;
  list_result_t pending_results [$];

  initial errors = 0;

  function automatic logic is_nil(input logic [8:0] link);
    return link[8];
  endfunction

  function automatic list_result_t list_view(input alm_pkg::alm_status_t st,
                                             input logic [8:0] slot);
    list_result_t r;
    r.status     = st;
    r.slot_used  = slot[7:0];
    r.head_slot  = is_nil(head_ptr) ? 8'd0 : head_ptr[7:0];
    r.list_empty = is_nil(head_ptr);
    return r;
  endfunction

  task automatic rebuild_pool();
    for (int i = 0; i < POOL; i++) begin
      next_of[i]      = 9'(i + 1);
      prev_of[i]      = (i == 0) ? LINK_NIL : 9'(i - 1);
      stored_value[i] = '0;
    end
    next_of[POOL-1] = LINK_NIL;
    head_ptr        = LINK_NIL;
    free_ptr        = '0;
    pending_results.delete();
  endtask

  // Applies one operation to the mirrored links; order of writes matters
  // when a corrupt delete makes a slot its own neighbor.
  function automatic list_result_t apply_list_op(input alm_pkg::alm_op_t op,
                                                 input logic [31:0] val,
                                                 input logic [7:0] idx);
    logic [8:0] slot;
    logic [8:0] prior_slot;
    logic [8:0] later_slot;
    if (op == alm_pkg::OP_INSERT) begin
      if (is_nil(free_ptr)) return list_view(alm_pkg::ST_FULL, '0);
      slot     = free_ptr;
      free_ptr = next_of[slot[7:0]];
      if (!is_nil(free_ptr)) prev_of[free_ptr[7:0]] = LINK_NIL;
      next_of[slot[7:0]] = head_ptr;
      prev_of[slot[7:0]] = LINK_NIL;
      if (!is_nil(head_ptr)) prev_of[head_ptr[7:0]] = slot;
      head_ptr                = slot;
      stored_value[slot[7:0]] = val;
      return list_view(alm_pkg::ST_OK, slot);
    end
    if (is_nil(head_ptr)) return list_view(alm_pkg::ST_EMPTY, '0);
    slot       = {1'b0, idx};
    prior_slot = prev_of[idx];
    later_slot = next_of[idx];
    if (!is_nil(prior_slot)) next_of[prior_slot[7:0]] = later_slot;
    else head_ptr = later_slot;
    later_slot = next_of[idx];
    if (!is_nil(later_slot)) prev_of[later_slot[7:0]] = prev_of[idx];
    next_of[idx] = free_ptr;
    prev_of[idx] = LINK_NIL;
    if (!is_nil(free_ptr)) prev_of[free_ptr[7:0]] = slot;
    free_ptr = slot;
    return list_view(alm_pkg::ST_OK, slot);
  endfunction

  task automatic log_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
  endtask

  always @(posedge clk) begin : monitor
    list_result_t want;
    if (!rst_n) begin
      rebuild_pool();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          log_mismatch("result beat with nothing pending", out_slot_used, 0);
        end else begin
          want = pending_results.pop_front();
          if (out_status !== want.status)
            log_mismatch("status", out_status, want.status);
          if (out_slot_used !== want.slot_used)
            log_mismatch("slot_used", out_slot_used, want.slot_used);
          if (out_head_slot !== want.head_slot)
            log_mismatch("head_slot", out_head_slot, want.head_slot);
          if (out_list_empty !== want.list_empty)
            log_mismatch("list_empty", out_list_empty, want.list_empty);
        end
      end
      if (in_valid && in_ready)
        pending_results.push_back(apply_list_op(alm_pkg::alm_op_t'(in_opcode), in_value,
                                                in_slot_index));
    end
  end

  always @(posedge end_of_test) begin
    if (pending_results.size() != 0)
      log_mismatch("results never delivered", 0, pending_results.size());
  end

endmodule

// ===== tb/sv/tb_array_linked_list_manager.sv =====
// Testbench top for the array linked list manager: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module tb_array_linked_list_manager;

  // Idle cycles tolerated with no beat on either channel. The worst honest
  // case is the clearing pass after reset plus the long receiver hold.
  localparam int STALL_LIMIT = 2000;
  localparam int IDLE_PCT    = 24;
  localparam int HOLD_AT     = 300;  // results seen before the long receiver hold
  localparam int HOLD_CYCLES = 80;
  localparam int BUSY_LO     = 500;  // window of beats with no idling on either side
  localparam int BUSY_HI     = 650;
  localparam int TAIL_CYCLES = 20;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_opcode;
  logic [31:0] in_value;
  logic [7:0]  in_slot_index;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [7:0]  out_slot_used;
  logic [7:0]  out_head_slot;
  logic        out_list_empty;
  logic        end_of_test;
  int          errors;

  // Bookkeeping for well-formed deletes: opcodes of beats still in the block,
  // and the slots known to be linked in the element list.
  alm_pkg::alm_op_t op_flight [$];
  logic [7:0]  live_slots [$];
  int          items_sent;
  int          results_seen = 0;
  int          quiet_cycles = 0;
  bit          beat_fire;
  bit          beat_ok;
  logic [7:0]  beat_slot;

  array_linked_list_manager #(.SLOTS(256)) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_opcode     (in_opcode),
    .in_value      (in_value),
    .in_slot_index (in_slot_index),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_slot_used (out_slot_used),
    .out_head_slot (out_head_slot),
    .out_list_empty(out_list_empty)
  );

  alm_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_opcode     (in_opcode),
    .in_value      (in_value),
    .in_slot_index (in_slot_index),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_slot_used (out_slot_used),
    .out_head_slot (out_head_slot),
    .out_list_empty(out_list_empty),
    .end_of_test   (end_of_test),
    .errors        (errors)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Capture result beats at the edge, book them on the falling edge so the
  // stimulus thread never races the live-slot update.
  always @(posedge clk) begin
    beat_fire <= rst_n && out_valid && out_ready;
    beat_slot <= out_slot_used;
    beat_ok   <= (out_status == alm_pkg::ST_OK);
    if (rst_n && out_valid && out_ready) results_seen <= results_seen + 1;
  end

  always @(negedge clk) begin
    if (beat_fire && op_flight.size() != 0) begin
      if (op_flight.pop_front() == alm_pkg::OP_INSERT && beat_ok)
        live_slots.push_back(beat_slot);
    end
  end

  // Watchdog: a run that stops moving beats is a failure.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("array_linked_list_manager regression: fail");
      $finish;
    end
  end

  // Receiver: random idling, one long hold so the block backs up into the
  // input, and a busy window with ready held high.
  initial begin : receiver
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (results_seen >= HOLD_AT && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else if (results_seen >= BUSY_LO && results_seen < BUSY_HI) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  function automatic int inserts_in_flight();
    int n;
    n = 0;
    foreach (op_flight[i]) if (op_flight[i] == alm_pkg::OP_INSERT) n++;
    return n;
  endfunction

  function automatic void drop_live(input logic [7:0] slot);
    foreach (live_slots[i]) begin
      if (live_slots[i] == slot) begin
        live_slots.delete(i);
        return;
      end
    end
  endfunction

  // One input beat; valid holds with a stable payload until accepted.
  task automatic send_item(input alm_pkg::alm_op_t op, input logic [31:0] val,
                           input logic [7:0] slot);
    bit busy;
    busy = (items_sent >= BUSY_LO && items_sent < BUSY_HI);
    if (!busy && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
    end
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_value      <= val;
    in_slot_index <= slot;
    do @(posedge clk); while (!in_ready);
    op_flight.push_back(op);
    items_sent++;
  endtask

  task automatic unlink_slot(input logic [7:0] slot);
    drop_live(slot);
    send_item(alm_pkg::OP_DELETE, $urandom, slot);
  endtask

  // Sender pause: nothing offered until every beat in flight has returned.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (op_flight.size() != 0) @(posedge clk);
  endtask

  // Random traffic. Deletes mostly target known live slots; noise_pct of
  // them hit any slot, which may corrupt both lists.
  task automatic run_phase(input int count, input int insert_pct, input int noise_pct);
    alm_pkg::alm_op_t op;
    logic [7:0] slot;
    int         pick;
    repeat (count) begin
      op   = ($urandom_range(99) < insert_pct) ? alm_pkg::OP_INSERT : alm_pkg::OP_DELETE;
      slot = 8'($urandom_range(255));
      if (op == alm_pkg::OP_DELETE && $urandom_range(99) >= noise_pct) begin
        if (live_slots.size() != 0) begin
          pick = $urandom_range(live_slots.size() - 1);
          slot = live_slots[pick];
          live_slots.delete(pick);
        end else if (inserts_in_flight() != 0) begin
          // list may not be empty yet; a blind delete would corrupt it
          op = alm_pkg::OP_INSERT;
        end
      end
      send_item(op, $urandom, slot);
    end
  endtask

  initial begin : stimulus
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_opcode     = alm_pkg::OP_INSERT;
    in_value      = '0;
    in_slot_index = '0;
    end_of_test   = 1'b0;
    items_sent    = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: deletes on an empty list, value extremes, then unlinking
    // the middle, the head and the tail, and slot reuse from the free list.
    send_item(alm_pkg::OP_DELETE, 32'h0, 8'd255);
    send_item(alm_pkg::OP_DELETE, 32'hffff_ffff, 8'd0);
    send_item(alm_pkg::OP_INSERT, 32'h8000_0000, 8'd0);
    send_item(alm_pkg::OP_INSERT, 32'h7fff_ffff, 8'd255);
    send_item(alm_pkg::OP_INSERT, 32'h0000_0000, 8'd0);
    send_item(alm_pkg::OP_INSERT, 32'hffff_ffff, 8'd0);
    send_item(alm_pkg::OP_INSERT, 32'h0000_0001, 8'd0);
    wait_drained();
    unlink_slot(8'd2);
    unlink_slot(8'd4);
    unlink_slot(8'd0);
    send_item(alm_pkg::OP_INSERT, 32'h5555_5555, 8'd0);
    send_item(alm_pkg::OP_INSERT, 32'haaaa_aaaa, 8'd0);
    wait_drained();
    unlink_slot(8'd1);
    unlink_slot(8'd3);
    unlink_slot(8'd0);
    unlink_slot(8'd4);
    send_item(alm_pkg::OP_DELETE, 32'h1234_5678, 8'd200);
    wait_drained();

    // Random: fill past pool full, drain past list empty, mix, then noise.
    run_phase(340, 92, 0);
    run_phase(340, 8, 0);
    run_phase(180, 50, 0);
    wait_drained();
    run_phase(140, 50, 50);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    end_of_test <= 1'b1;
    @(posedge clk);
    @(posedge clk);
    if (errors == 0) begin
      $display("array_linked_list_manager regression: pass");
    end else begin
      $display("array_linked_list_manager regression: fail");
    end
    $finish;
  end

endmodule
